[src/mpu_pkg.sv]
// Shared definitions for the masked pixel unpacker: register indexes, limits,
// luma weights and the mask shift helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpu_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned SHIFT_W     = 5;

  // Luma weights, unsigned 0.16 fixed point
  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RED_MASK     = 3'd0,
    REG_GREEN_MASK   = 3'd1,
    REG_BLUE_MASK    = 3'd2,
    REG_ALPHA_MASK   = 3'd3,
    REG_BPP          = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } cfg_reg_t;

  // Trailing-zero count of a mask: isolate the lowest set bit, then encode.
  function automatic logic [SHIFT_W-1:0] mask_shift(input logic [CFG_DATA_W-1:0] m);
    logic [CFG_DATA_W-1:0] low_bit;
    logic [SHIFT_W-1:0]    enc;
    low_bit = m & (~m + 32'd1);
    enc = '0;
    for (int i = 0; i < CFG_DATA_W; i++) begin
      if (low_bit[i]) enc = enc | SHIFT_W'(i);
    end
    return enc;
  endfunction

endpackage
`default_nettype wire

[src/masked_pixel_unpacker.sv]
// Bitmap pixel-array unpacker: bytes in, masked RGBA channels and luma out.
// Depends on mpu_pkg.
//
// Usage: bytes of the pixel array enter on in_valid/in_ready with data_byte,
// one beat per cycle while in_ready is high. Each group of bytes_per_pixel
// bytes (clamped to 2..4, little-endian) forms a pixel; row padding bytes are
// consumed without a result. Every pixel produces one beat on out_valid/out_ready
// carrying red, green, blue, alpha, luma, column, row and last_of_image.
// Throughput is one byte per cycle while in_ready is high. The stage-1
// register captures the assembled pixel at the edge that accepts its final
// byte; the channel extraction register loads from it and the luma/result
// register from that one; out_valid rises as the result register loads. The
// luma multiply-add and the mask barrel shift each own one of these stages.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the
// block is idle; it takes effect on the next byte.
// Reset (rst, synchronous) restores the default masks (24-bit BGR),
// 3 bytes per pixel, 640x480, and clears the assembly state and counters.
// When the receiver stalls, the result register holds and the stages behind
// it fill; in_ready falls once all three are occupied.
`timescale 1ns / 1ps
`default_nettype none
module masked_pixel_unpacker import mpu_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [7:0]                  alpha,
  output logic [7:0]                  luma,
  output logic [POS_W-1:0]            column,
  output logic [POS_W-1:0]            row,
  output logic                        last_of_image
);

  // Configuration
  logic [CFG_DATA_W-1:0] red_mask, green_mask, blue_mask, alpha_mask;
  logic [SHIFT_W-1:0]    red_sh, green_sh, blue_sh, alpha_sh;
  logic [2:0]            bytes_per_pixel;
  logic [DIM_W-1:0]      image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_mask        <= 32'h00FF_0000;
      green_mask      <= 32'h0000_FF00;
      blue_mask       <= 32'h0000_00FF;
      alpha_mask      <= '0;
      red_sh          <= SHIFT_W'(16);
      green_sh        <= SHIFT_W'(8);
      blue_sh         <= '0;
      alpha_sh        <= '0;
      bytes_per_pixel <= 3'd3;
      image_width     <= DIM_W'(640);
      image_height    <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RED_MASK: begin
          red_mask <= cfg_wdata;
          red_sh   <= mask_shift(cfg_wdata);
        end
        REG_GREEN_MASK: begin
          green_mask <= cfg_wdata;
          green_sh   <= mask_shift(cfg_wdata);
        end
        REG_BLUE_MASK: begin
          blue_mask <= cfg_wdata;
          blue_sh   <= mask_shift(cfg_wdata);
        end
        REG_ALPHA_MASK: begin
          alpha_mask <= cfg_wdata;
          alpha_sh   <= mask_shift(cfg_wdata);
        end
        REG_BPP:          bytes_per_pixel <= cfg_wdata[2:0];
        REG_IMAGE_WIDTH:  image_width     <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height    <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pixel size and dimensions
  logic [2:0]       bpp_eff;
  logic [DIM_W-1:0] width_eff, height_eff;

  always_comb begin
    if (bytes_per_pixel < 3'd2)      bpp_eff = 3'd2;
    else if (bytes_per_pixel > 3'd4) bpp_eff = 3'd4;
    else                             bpp_eff = bytes_per_pixel;
    if (image_width == '0)                        width_eff = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH))     width_eff = DIM_W'(MAX_WIDTH);
    else                                          width_eff = image_width;
    if (image_height == '0)                       height_eff = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT))   height_eff = DIM_W'(MAX_HEIGHT);
    else                                          height_eff = image_height;
  end

  // Pipeline handshake
  logic s1_valid, s2_valid;
  logic out_free, s2_free, s1_free, in_fire;

  assign out_free = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;

  // Pixel assembly
  logic [31:0]      pixel_word, pixel_word_next, word_merged;
  logic [1:0]       byte_slot, byte_slot_next;
  logic [1:0]       pad_left, pad_left_next;
  logic [POS_W-1:0] column_count, column_count_next;
  logic [POS_W-1:0] row_count, row_count_next;
  logic [2:0]       slot_plus;
  logic [1:0]       row_bytes_low;
  logic             pixel_done, row_end, image_end;

  always_comb begin
    word_merged   = pixel_word | (32'(data_byte) << {byte_slot, 3'b000});
    slot_plus     = {1'b0, byte_slot} + 3'd1;
    row_end       = ({1'b0, column_count} + DIM_W'(1)) >= width_eff;
    image_end     = ({1'b0, row_count} + DIM_W'(1)) >= height_eff;
    row_bytes_low = 2'(width_eff[1:0] * bpp_eff[1:0]);
    pixel_done    = 1'b0;

    pixel_word_next   = pixel_word;
    byte_slot_next    = byte_slot;
    pad_left_next     = pad_left;
    column_count_next = column_count;
    row_count_next    = row_count;

    if (in_fire) begin
      if (pad_left != 2'd0) begin
        pad_left_next = pad_left - 2'd1;
      end else if (slot_plus < bpp_eff) begin
        pixel_word_next = word_merged;
        byte_slot_next  = slot_plus[1:0];
      end else begin
        pixel_done      = 1'b1;
        pixel_word_next = '0;
        byte_slot_next  = '0;
        if (row_end) begin
          pad_left_next     = 2'd0 - row_bytes_low;
          column_count_next = '0;
          row_count_next    = image_end ? '0 : row_count + POS_W'(1);
        end else begin
          column_count_next = column_count + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_word   <= '0;
      byte_slot    <= '0;
      pad_left     <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      pixel_word   <= pixel_word_next;
      byte_slot    <= byte_slot_next;
      pad_left     <= pad_left_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage 1: assembled pixel
  logic [31:0]      s1_word;
  logic [POS_W-1:0] s1_col, s1_row;
  logic             s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_done) begin
      s1_valid <= 1'b1;
    end else if (s2_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_done) begin
      s1_word <= word_merged;
      s1_col  <= column_count;
      s1_row  <= row_count;
      s1_last <= row_end && image_end;
    end
  end

  // Stage 2: masked channel extraction
  logic [7:0]       s2_red, s2_green, s2_blue, s2_alpha;
  logic [POS_W-1:0] s2_col, s2_row;
  logic             s2_last;
  logic             s2_load;

  assign s2_load = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_red   <= 8'((s1_word & red_mask) >> red_sh);
      s2_green <= 8'((s1_word & green_mask) >> green_sh);
      s2_blue  <= 8'((s1_word & blue_mask) >> blue_sh);
      s2_alpha <= 8'((s1_word & alpha_mask) >> alpha_sh);
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_last  <= s1_last;
    end
  end

  // Stage 3: luma and result register
  logic [23:0] luma_sum;
  logic        out_load;

  assign out_load = s2_valid && out_free;
  // Products need 24 bits; the weights sum to 1.0 so the total cannot overflow
  assign luma_sum = 24'(LUMA_WR) * 24'(s2_red) + 24'(LUMA_WG) * 24'(s2_green)
                  + 24'(LUMA_WB) * 24'(s2_blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red           <= s2_red;
      green         <= s2_green;
      blue          <= s2_blue;
      alpha         <= s2_alpha;
      luma          <= luma_sum[23:16];
      column        <= s2_col;
      row           <= s2_row;
      last_of_image <= s2_last;
    end
  end

  // Checks
  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    pixel_done && row_end && image_end |=> column_count == '0 && row_count == '0)
    else $error("counters did not wrap after the last pixel");

  a_pad_clean: assert property (@(posedge clk) disable iff (rst)
    pad_left != 2'd0 |-> byte_slot == 2'd0 && pixel_word == '0)
    else $error("padding pending while a pixel is part-assembled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    pixel_done |-> !s1_valid || s2_free)
    else $error("assembled pixel overwrote an occupied stage");

endmodule
`default_nettype wire
